// ===== rtl/lpi_pkg.sv =====
// shared types, widths and constants for the line pair intersection block
package lpi_pkg;

  localparam int COORD_BITS      = 24;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int MIN_DET_BITS    = 20;
  localparam int PARAM_BITS      = 32;

  // differences of two coordinates
  localparam int DIFF_BITS = COORD_BITS + 1;
  // product of two differences
  localparam int PROD_BITS = 2 * DIFF_BITS;
  // difference of two products (determinant and numerators)
  localparam int NUM_BITS  = PROD_BITS + 1;
  // magnitudes
  localparam int MAG_BITS  = NUM_BITS;
  // quotient bits: integer part of |num|/|den| plus fraction bits
  localparam int QUO_BITS  = MAG_BITS + PARAM_FRAC_BITS;
  // partial remainder needs one extra bit over the divisor
  localparam int REM_BITS  = MAG_BITS + 1;
  // quotient bits held per cell; one bit resolved per cell
  localparam int CAP_BITS  = PARAM_BITS + 2;
  localparam logic [CAP_BITS-1:0] QCAP = CAP_BITS'(64'd1 << (PARAM_BITS + 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NUM_BITS-1:0]   num_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic [REM_BITS-1:0]          rem_t;
  typedef logic [CAP_BITS-1:0]          quo_t;

  // one division lane as carried down the chain
  typedef struct packed {
    rem_t rem;
    mag_t num;   // remaining dividend bits, msb first
    quo_t quo;
    logic neg;
  } lane_t;

  // per-item control carried beside the lanes
  typedef struct packed {
    logic valid;
    logic found;
  } ctl_t;

endpackage

// ===== rtl/line_pair_intersection_params.sv =====
// top level of the line pair intersection parameter block
//
// usage:
//   request channel: drive the eight Q16.8 endpoint coordinates and pulse
//   start; busy is always low, so a request is taken in every cycle
//   config channel: cfg_valid/cfg_ready write min_determinant; cfg_ready is
//   always high; write only while no request is in flight
//   result channel: done is high for exactly one cycle with found,
//   first_param, second_param and clipped; the receiver cannot stall
// pipeline: front stages for differences, products and determinant test, a
//   chain of division cells (MAG_BITS + PARAM_FRAC_BITS cells), and a back
//   stage for clamp and sign
// throughput: one request per cycle, set by the fully pipelined chain of
//   division cells, one quotient bit per cell for both parameters
// reset: rst clears all valid flags; min_determinant returns to 1
module line_pair_intersection_params (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  lpi_pkg::coord_t                       first_start_x,
  input  lpi_pkg::coord_t                       first_start_y,
  input  lpi_pkg::coord_t                       first_end_x,
  input  lpi_pkg::coord_t                       first_end_y,
  input  lpi_pkg::coord_t                       second_start_x,
  input  lpi_pkg::coord_t                       second_start_y,
  input  lpi_pkg::coord_t                       second_end_x,
  input  lpi_pkg::coord_t                       second_end_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lpi_pkg::MIN_DET_BITS-1:0]      cfg_data,
  output logic                                  done,
  output logic                                  found,
  output logic signed [lpi_pkg::PARAM_BITS-1:0] first_param,
  output logic signed [lpi_pkg::PARAM_BITS-1:0] second_param,
  output logic                                  clipped
);
  import lpi_pkg::*;

  // one cell per dividend bit plus one per fraction bit
  localparam int NCELLS = QUO_BITS;

  logic [MIN_DET_BITS-1:0] min_determinant;

  ctl_t  ctl  [NCELLS+1];
  mag_t  den  [NCELLS+1];
  lane_t ln1  [NCELLS+1];
  lane_t ln2  [NCELLS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_determinant <= MIN_DET_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      min_determinant <= cfg_data;
    end
  end

  lpi_front u_front (
    .clk, .rst,
    .in_valid (start && !busy),
    .p1x (first_start_x), .p1y (first_start_y),
    .e1x (first_end_x),   .e1y (first_end_y),
    .p2x (second_start_x), .p2y (second_start_y),
    .e2x (second_end_x),   .e2y (second_end_y),
    .min_det   (min_determinant),
    .ctl_out   (ctl[0]),
    .den_out   (den[0]),
    .lane1_out (ln1[0]),
    .lane2_out (ln2[0])
  );

  // chain of division cells, each resolving one quotient bit
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    lpi_cell u_cell (
      .clk, .rst,
      .ctl_in    (ctl[i]),
      .den_in    (den[i]),
      .lane1_in  (ln1[i]),
      .lane2_in  (ln2[i]),
      .ctl_out   (ctl[i+1]),
      .den_out   (den[i+1]),
      .lane1_out (ln1[i+1]),
      .lane2_out (ln2[i+1])
    );
  end

  lpi_back u_back (
    .clk, .rst,
    .ctl_in   (ctl[NCELLS]),
    .lane1_in (ln1[NCELLS]),
    .lane2_in (ln2[NCELLS]),
    .done, .found, .first_param, .second_param, .clipped
  );

  // a result that is not found carries zero payload
  a_zero_when_parallel: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> first_param == '0 && second_param == '0 && !clipped)
    else $error("parallel result with nonzero payload");

  // a clipped parameter sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    done && clipped |-> first_param == 32'sh7fffffff || first_param == 32'sh80000000 ||
                        second_param == 32'sh7fffffff || second_param == 32'sh80000000)
    else $error("clipped without a saturated parameter");

  // control valid flags follow the chain one cell per cycle
  a_chain_move: assert property (@(posedge clk) disable iff (rst)
    ctl[0].valid |=> ctl[1].valid)
    else $error("request lost entering the cell chain");

endmodule

// ===== rtl/lpi_front.sv =====
// front end: differences, products, determinant test, lane setup
module lpi_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  lpi_pkg::coord_t                     p1x,
  input  lpi_pkg::coord_t                     p1y,
  input  lpi_pkg::coord_t                     e1x,
  input  lpi_pkg::coord_t                     e1y,
  input  lpi_pkg::coord_t                     p2x,
  input  lpi_pkg::coord_t                     p2y,
  input  lpi_pkg::coord_t                     e2x,
  input  lpi_pkg::coord_t                     e2y,
  input  logic [lpi_pkg::MIN_DET_BITS-1:0]    min_det,
  output lpi_pkg::ctl_t                       ctl_out,
  output lpi_pkg::mag_t                       den_out,
  output lpi_pkg::lane_t                      lane1_out,
  output lpi_pkg::lane_t                      lane2_out
);
  import lpi_pkg::*;

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  diff_t v1x, v1y, v2x, v2y, bx, by;
  diff_t r_v1x, r_v1y, r_v2x, r_v2y, r_bx, r_by;
  logic  v_s1;
  prod_t m_d0, m_d1, m_a0, m_a1, m_b0, m_b1;
  logic  v_s2;
  num_t  det, n1, n2;
  mag_t  adet, an1, an2;

  assign v1x = diff_t'(e1x) - diff_t'(p1x);
  assign v1y = diff_t'(e1y) - diff_t'(p1y);
  assign v2x = diff_t'(e2x) - diff_t'(p2x);
  assign v2y = diff_t'(e2y) - diff_t'(p2y);
  assign bx  = diff_t'(p2x) - diff_t'(p1x);
  assign by  = diff_t'(p2y) - diff_t'(p1y);

  // stage 1: register differences
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else begin
      v_s1 <= in_valid;
    end
    r_v1x <= v1x; r_v1y <= v1y; r_v2x <= v2x;
    r_v2y <= v2y; r_bx <= bx; r_by <= by;
  end

  // stage 2: six products, each registered
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s2 <= 1'b0;
    end else begin
      v_s2 <= v_s1;
    end
    m_d0 <= prod_t'(r_v2x) * prod_t'(r_v1y);
    m_d1 <= prod_t'(r_v1x) * prod_t'(r_v2y);
    m_a0 <= prod_t'(r_v2x) * prod_t'(r_by);
    m_a1 <= prod_t'(r_bx) * prod_t'(r_v2y);
    m_b0 <= prod_t'(r_v1x) * prod_t'(r_by);
    m_b1 <= prod_t'(r_bx) * prod_t'(r_v1y);
  end

  assign det  = num_t'(m_d0) - num_t'(m_d1);
  assign n1   = num_t'(m_a0) - num_t'(m_a1);
  assign n2   = num_t'(m_b0) - num_t'(m_b1);
  assign adet = det[NUM_BITS-1] ? mag_t'(-det) : mag_t'(det);
  assign an1  = n1[NUM_BITS-1] ? mag_t'(-n1) : mag_t'(n1);
  assign an2  = n2[NUM_BITS-1] ? mag_t'(-n2) : mag_t'(n2);

  // stage 3: determinant test and lane load
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= v_s2;
      ctl_out.found <= (adet != '0) && (adet >= mag_t'(min_det));
    end
    den_out        <= adet;
    lane1_out.rem  <= '0;
    lane1_out.num  <= an1;
    lane1_out.quo  <= '0;
    lane1_out.neg  <= n1[NUM_BITS-1] ^ det[NUM_BITS-1];
    lane2_out.rem  <= '0;
    lane2_out.num  <= an2;
    lane2_out.quo  <= '0;
    lane2_out.neg  <= n2[NUM_BITS-1] ^ det[NUM_BITS-1];
  end

endmodule

// ===== rtl/lpi_cell.sv =====
// one restoring division step for both lanes, registered
module lpi_cell (
  input  logic            clk,
  input  logic            rst,
  input  lpi_pkg::ctl_t   ctl_in,
  input  lpi_pkg::mag_t   den_in,
  input  lpi_pkg::lane_t  lane1_in,
  input  lpi_pkg::lane_t  lane2_in,
  output lpi_pkg::ctl_t   ctl_out,
  output lpi_pkg::mag_t   den_out,
  output lpi_pkg::lane_t  lane1_out,
  output lpi_pkg::lane_t  lane2_out
);
  import lpi_pkg::*;

  function automatic lane_t step(lane_t l, mag_t d);
    rem_t  r;
    quo_t  q;
    lane_t o;
    r = {l.rem[REM_BITS-2:0], l.num[MAG_BITS-1]};
    q = {l.quo[CAP_BITS-2:0], 1'b0};
    if (r >= rem_t'(d)) begin
      r = r - rem_t'(d);
      q[0] = 1'b1;
    end
    if (q > QCAP) q = QCAP;
    // saturated state never leaves the cap, so doubling of a capped value stays safe
    if (l.quo >= QCAP) q = QCAP;
    o.rem = r;
    o.num = {l.num[MAG_BITS-2:0], 1'b0};
    o.quo = q;
    o.neg = l.neg;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    den_out   <= den_in;
    lane1_out <= step(lane1_in, den_in);
    lane2_out <= step(lane2_in, den_in);
  end

endmodule

// ===== rtl/lpi_back.sv =====
// back end: clamp, sign and result register
module lpi_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpi_pkg::ctl_t                        ctl_in,
  input  lpi_pkg::lane_t                       lane1_in,
  input  lpi_pkg::lane_t                       lane2_in,
  output logic                                 done,
  output logic                                 found,
  output logic signed [lpi_pkg::PARAM_BITS-1:0] first_param,
  output logic signed [lpi_pkg::PARAM_BITS-1:0] second_param,
  output logic                                 clipped
);
  import lpi_pkg::*;

  typedef logic [PARAM_BITS-1:0] par_t;

  logic c1, c2;
  par_t q1, q2;

  function automatic par_t finish(lane_t l, output logic c);
    quo_t lim;
    quo_t q;
    lim = l.neg ? quo_t'(64'd1 << (PARAM_BITS - 1))
                : quo_t'((64'd1 << (PARAM_BITS - 1)) - 64'd1);
    q = l.quo;
    c = 1'b0;
    if (q > lim) begin
      q = lim;
      c = 1'b1;
    end
    if (l.neg) q = -q;
    return q[PARAM_BITS-1:0];
  endfunction

  always_comb begin
    q1 = finish(lane1_in, c1);
    q2 = finish(lane2_in, c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    found        <= ctl_in.found;
    first_param  <= ctl_in.found ? q1 : '0;
    second_param <= ctl_in.found ? q2 : '0;
    clipped      <= ctl_in.found & (c1 | c2);
  end

endmodule

// ===== dv/line_pair_intersection_params_checker.sv =====
// checker for the line pair intersection block: predicts each result and compares
`timescale 1ns / 100ps
module line_pair_intersection_params_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  lpi_pkg::coord_t                       first_start_x,
  input  lpi_pkg::coord_t                       first_start_y,
  input  lpi_pkg::coord_t                       first_end_x,
  input  lpi_pkg::coord_t                       first_end_y,
  input  lpi_pkg::coord_t                       second_start_x,
  input  lpi_pkg::coord_t                       second_start_y,
  input  lpi_pkg::coord_t                       second_end_x,
  input  lpi_pkg::coord_t                       second_end_y,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [lpi_pkg::MIN_DET_BITS-1:0]      cfg_data,
  input  logic                                  done,
  input  logic                                  found,
  input  logic signed [lpi_pkg::PARAM_BITS-1:0] first_param,
  input  logic signed [lpi_pkg::PARAM_BITS-1:0] second_param,
  input  logic                                  clipped,
  output int                                    errors,
  output int                                    pending
);
  import lpi_pkg::*;

  typedef struct {
    logic                         hit;
    logic signed [PARAM_BITS-1:0] s1;
    logic signed [PARAM_BITS-1:0] s2;
    logic                         sat;
  } crossing_t;

  crossing_t crossings_due[$];
  logic [MIN_DET_BITS-1:0] det_floor;

  // truncated fixed point quotient with saturation
  function automatic logic [PARAM_BITS-1:0] fixed_quot(longint n, longint d, ref logic sat);
    logic         neg;
    logic [127:0] nm;
    logic [127:0] dm;
    logic [127:0] q;
    logic [127:0] lim;
    neg = (n < 0) != (d < 0);
    nm = n < 0 ? 128'(-n) : 128'(n);
    dm = d < 0 ? 128'(-d) : 128'(d);
    q = (nm << PARAM_FRAC_BITS) / dm;
    lim = neg ? (128'd1 << 31) : (128'd1 << 31) - 1;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[PARAM_BITS-1:0] : q[PARAM_BITS-1:0];
  endfunction

  function automatic crossing_t solve_pair();
    crossing_t r;
    longint v1x, v1y, v2x, v2y, bx, by, det, adet;
    v1x = longint'(first_end_x) - longint'(first_start_x);
    v1y = longint'(first_end_y) - longint'(first_start_y);
    v2x = longint'(second_end_x) - longint'(second_start_x);
    v2y = longint'(second_end_y) - longint'(second_start_y);
    bx = longint'(second_start_x) - longint'(first_start_x);
    by = longint'(second_start_y) - longint'(first_start_y);
    det = v2x * v1y - v1x * v2y;
    adet = det < 0 ? -det : det;
    r = '{1'b0, '0, '0, 1'b0};
    // zero determinant is parallel even with a zero floor
    if (det == 0 || adet < longint'(det_floor)) return r;
    r.hit = 1'b1;
    r.s1 = fixed_quot(v2x * by - bx * v2y, det, r.sat);
    r.s2 = fixed_quot(v1x * by - bx * v1y, det, r.sat);
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t e;
    if (rst) begin
      det_floor <= 1;
      crossings_due.delete();
      errors <= 0;
    end else begin
      if (start && !busy) crossings_due.push_back(solve_pair());
      if (cfg_valid && cfg_ready) det_floor <= cfg_data;
      if (done) begin
        if (crossings_due.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          e = crossings_due.pop_front();
          if (found !== e.hit || first_param !== e.s1 || second_param !== e.s2 ||
              clipped !== e.sat) begin
            if (found !== e.hit) $error("found: expected %0d, got %0d", e.hit, found);
            if (first_param !== e.s1)
              $error("first_param: expected %0d, got %0d", e.s1, first_param);
            if (second_param !== e.s2)
              $error("second_param: expected %0d, got %0d", e.s2, second_param);
            if (clipped !== e.sat) $error("clipped: expected %0d, got %0d", e.sat, clipped);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = crossings_due.size();

endmodule

// ===== dv/line_pair_intersection_params_test.sv =====
// top of the line pair intersection testbench: stimulus, config phases and verdict
`timescale 1ns / 100ps
module line_pair_intersection_params_test;
  import lpi_pkg::*;

  localparam int LATENCY = 3 + MAG_BITS + PARAM_FRAC_BITS + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t pts [8];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MIN_DET_BITS-1:0] cfg_data = '0;
  logic done, found, clipped;
  logic signed [PARAM_BITS-1:0] first_param, second_param;
  int errors, pending;
  int idle_pct;

  initial for (int i = 0; i < 8; i++) pts[i] = '0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_pair_intersection_params i_dut (
    .clk, .rst, .start, .busy,
    .first_start_x(pts[0]), .first_start_y(pts[1]),
    .first_end_x(pts[2]), .first_end_y(pts[3]),
    .second_start_x(pts[4]), .second_start_y(pts[5]),
    .second_end_x(pts[6]), .second_end_y(pts[7]),
    .cfg_valid, .cfg_ready, .cfg_data,
    .done, .found, .first_param, .second_param, .clipped
  );

  line_pair_intersection_params_checker i_checker (
    .clk, .rst, .start, .busy,
    .first_start_x(pts[0]), .first_start_y(pts[1]),
    .first_end_x(pts[2]), .first_end_y(pts[3]),
    .second_start_x(pts[4]), .second_start_y(pts[5]),
    .second_end_x(pts[6]), .second_end_y(pts[7]),
    .cfg_valid, .cfg_ready, .cfg_data,
    .done, .found, .first_param, .second_param, .clipped,
    .errors, .pending
  );

  // one request: hold start until an edge sees busy low, then maybe idle
  task automatic send(input coord_t c [8]);
    logic was_busy;
    @(negedge clk);
    pts = c;
    start = 1'b1;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  // drain the pipe, let the tail settle, then write the threshold
  task automatic set_floor(input logic [MIN_DET_BITS-1:0] v);
    logic was_ready;
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    forever begin
      was_ready = cfg_ready;
      @(posedge clk);
      if (was_ready) break;
      @(negedge clk);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t rnd_near(input int span);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // random pair: plain crossings, plus near parallel, tiny and wild ones
  task automatic send_random();
    coord_t c [8];
    int mode, k, dx, dy;
    mode = $urandom_range(9);
    if (mode < 3) begin
      for (int i = 0; i < 8; i++) c[i] = rnd_full();
    end else if (mode < 6) begin
      for (int i = 0; i < 8; i++) c[i] = rnd_near(4096);
    end else if (mode < 8) begin
      // second line nearly a multiple of the first direction
      for (int i = 0; i < 4; i++) c[i] = rnd_near(1 << 20);
      k = $urandom_range(4) + 1;
      dx = int'(c[2]) - int'(c[0]);
      dy = int'(c[3]) - int'(c[1]);
      c[4] = rnd_near(1 << 20);
      c[5] = rnd_near(1 << 20);
      c[6] = coord_t'(int'(c[4]) + k * dx + $urandom_range(2) - 1);
      c[7] = coord_t'(int'(c[5]) + k * dy + $urandom_range(2) - 1);
    end else begin
      // tiny directions, far offset: pushes the parameters toward saturation
      for (int i = 0; i < 8; i++) c[i] = rnd_near(4);
      c[4] = rnd_full();
      c[5] = rnd_full();
      c[6] = coord_t'(int'(c[4]) + $urandom_range(6) - 3);
      c[7] = coord_t'(int'(c[5]) + $urandom_range(6) - 3);
    end
    send(c);
  endtask

  task automatic send_pts(input int a, b, cc, d, e, f, g, h);
    coord_t c [8];
    c = '{coord_t'(a), coord_t'(b), coord_t'(cc), coord_t'(d),
          coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
    send(c);
  endtask

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  initial begin
    idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: degenerate, crossings, parallel, extremes, saturation
    send_pts(0, 0, 0, 0, 0, 0, 0, 0);
    send_pts(0, 0, 256, 0, 128, -128, 128, 128);
    send_pts(0, 0, 256, 256, 0, 256, 256, 512);
    send_pts(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    send_pts(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
    send_pts(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);
    send_pts(0, 0, 1, 0, 0, CMAX, 1, CMAX - 1);
    send_pts(0, 0, 1, 0, CMIN, CMAX, CMIN + 1, CMAX - 1);
    send_pts(0, 0, -1, 0, CMAX, CMIN, CMAX - 1, CMIN + 1);
    send_pts(0, 0, 1, 1, 0, 1, 1, 1);
    send_pts(-1, -1, -1, -1, -1, -1, -1, -1);
    send_pts(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);

    // zero floor: a zero determinant must still read as parallel
    set_floor('0);
    send_pts(0, 0, 256, 256, 512, 0, 768, 256);
    send_pts(0, 0, 1, 0, 0, 5, 1, 5);
    send_pts(0, 0, 1, 0, 0, 5, 0, 6);
    set_floor('1);
    send_pts(0, 0, 1024, 0, 0, 0, 0, 1023);
    send_pts(0, 0, 1024, 0, 0, 0, 0, 1024);
    send_pts(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);

    // random phases: sender busy, sender mostly idle, back to back
    set_floor(1);
    idle_pct = 13;
    repeat (270) send_random();
    set_floor(20'($urandom_range(4095)));
    idle_pct = 87;
    repeat (270) send_random();
    set_floor(20'($urandom));
    idle_pct = 0;
    repeat (130) send_random();
    set_floor(0);
    repeat (130) send_random();

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lpi_pkg.sv
rtl/lpi_front.sv
rtl/lpi_cell.sv
rtl/lpi_back.sv
rtl/line_pair_intersection_params.sv
dv/line_pair_intersection_params_checker.sv
dv/line_pair_intersection_params_test.sv
